// ===== rtl/m3i_pkg.sv =====
// Shared types, constants and tables for the 3x3 matrix inverse mod 95.
// Used by every module of the block but m3i_chk; depends on nothing.
`default_nettype none

package m3i_pkg;

    localparam int MODULUS = 95;
    localparam int RES_W   = 7;                 // one residue 0..94
    localparam int PROD_W  = 2 * RES_W;         // product of two residues
    localparam int RED_W   = 15;                // widest value fed to a reducer
    localparam int RECIP   = 689;               // floor(2^16 / 95)
    localparam int RECIP_W = 10;
    localparam int RSHIFT  = 16;
    localparam int Q_W     = RED_W + RECIP_W - RSHIFT;
    localparam int COF_OFS = MODULUS * (MODULUS - 1);   // keeps a cofactor difference positive
    localparam int NSTG    = 13;                // pipeline stages, input to result
    localparam int TBL_N   = 1 << RES_W;

    typedef logic [RES_W-1:0] res_t;

    typedef struct packed {
        res_t [8:0] cof;    // reduced cofactors, in result order
        res_t [2:0] row0;   // reduced row 0 of the input matrix
    } cof_bus_t;

    typedef struct packed {
        res_t [8:0] cof;
        res_t       dinv;   // inverse of the determinant, zero if none exists
        logic       ok;
    } scl_bus_t;

    typedef logic [TBL_N-1:0][RES_W-1:0] inv_tbl_t;

    function automatic inv_tbl_t build_inv_tbl();
        inv_tbl_t t;
        t = '0;
        for (int d = 1; d < MODULUS; d++) begin
            for (int k = 1; k < MODULUS; k++) begin
                if ((d * k) % MODULUS == 1) begin
                    t[d] = RES_W'(k);
                end
            end
        end
        return t;
    endfunction

    localparam inv_tbl_t INV_TBL = build_inv_tbl();

endpackage

`default_nettype wire

// ===== rtl/m3i_red95.sv =====
// Two-stage reduction mod 95 of a value below 2^15: reciprocal estimate, then
// subtract and one correction. Depends on m3i_pkg.
`default_nettype none

module m3i_red95 (
    input  wire logic                     aclk,
    input  wire logic [1:0]               ce,
    input  wire logic [m3i_pkg::RED_W-1:0] x,
    output      m3i_pkg::res_t            r
);
    import m3i_pkg::*;

    localparam int P_W = RED_W + RECIP_W;

    logic [P_W-1:0]   prod;
    logic [RED_W-1:0] x_reg;
    logic [Q_W-1:0]   q_reg;
    logic [Q_W-1:0]   q_next;
    logic [RED_W-1:0] t;
    res_t             r_reg;
    res_t             r_next;

    // the estimate never exceeds floor(x / 95) and falls short by at most one
    assign prod   = P_W'(x) * P_W'(RECIP);
    assign q_next = prod[P_W-1:RSHIFT];

    always_ff @(posedge aclk) begin
        if (ce[0]) begin
            x_reg <= x;
            q_reg <= q_next;
        end
    end

    always_comb begin
        t      = x_reg - RED_W'(q_reg) * RED_W'(MODULUS);
        r_next = (t >= RED_W'(MODULUS)) ? RES_W'(t - RED_W'(MODULUS)) : RES_W'(t);
    end

    always_ff @(posedge aclk) begin
        if (ce[1]) begin
            r_reg <= r_next;
        end
    end

    assign r = r_reg;

endmodule

`default_nettype wire

// ===== rtl/m3i_cofactor.sv =====
// Input reduction and the nine signed 2x2 cofactors reduced mod 95 (5 stages).
// Depends on m3i_pkg and m3i_red95.
`default_nettype none

module m3i_cofactor (
    input  wire logic            aclk,
    input  wire logic [4:0]      ce,
    input  wire m3i_pkg::res_t [8:0] raw,
    output      m3i_pkg::cof_bus_t   cob
);
    import m3i_pkg::*;

    res_t [8:0]              a_reg;
    logic [17:0][PROD_W-1:0] p_reg;
    logic [8:0][RED_W-1:0]   cd_reg;
    res_t [8:0]              cof;
    res_t [2:0]              r1_reg, r2_reg, r3_reg, r4_reg;

    // stage 0: fold 95..127 into range
    always_ff @(posedge aclk) begin
        if (ce[0]) begin
            for (int k = 0; k < 9; k++) begin
                a_reg[k] <= (raw[k] >= RES_W'(MODULUS)) ? raw[k] - RES_W'(MODULUS) : raw[k];
            end
        end
    end

    // inverse entry (i,j) takes the cofactor of input entry (j,i)
    for (genvar gi = 0; gi < 3; gi++) begin : g_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_col
            localparam int R0 = (gj + 1) % 3;
            localparam int R1 = (gj + 2) % 3;
            localparam int C0 = (gi + 1) % 3;
            localparam int C1 = (gi + 2) % 3;
            localparam int K  = gi * 3 + gj;

            always_ff @(posedge aclk) begin
                if (ce[1]) begin
                    p_reg[2*K]   <= PROD_W'(a_reg[R0*3+C0]) * PROD_W'(a_reg[R1*3+C1]);
                    p_reg[2*K+1] <= PROD_W'(a_reg[R0*3+C1]) * PROD_W'(a_reg[R1*3+C0]);
                end
                if (ce[2]) begin
                    cd_reg[K] <= RED_W'(p_reg[2*K]) + RED_W'(COF_OFS) - RED_W'(p_reg[2*K+1]);
                end
            end

            m3i_red95 u_red (
                .aclk (aclk),
                .ce   (ce[4:3]),
                .x    (cd_reg[K]),
                .r    (cof[K])
            );
        end
    end

    // carry row 0 along for the determinant
    always_ff @(posedge aclk) begin
        if (ce[1]) r1_reg <= a_reg[2:0];
        if (ce[2]) r2_reg <= r1_reg;
        if (ce[3]) r3_reg <= r2_reg;
        if (ce[4]) r4_reg <= r3_reg;
    end

    assign cob.cof  = cof;
    assign cob.row0 = r4_reg;

endmodule

`default_nettype wire

// ===== rtl/m3i_det.sv =====
// Determinant from row 0 and its cofactors, reduction mod 95 and table lookup
// of its inverse (5 stages). Depends on m3i_pkg and m3i_red95.
`default_nettype none

module m3i_det (
    input  wire logic              aclk,
    input  wire logic [4:0]        ce,
    input  wire m3i_pkg::cof_bus_t cin,
    output      m3i_pkg::scl_bus_t sout
);
    import m3i_pkg::*;

    logic [2:0][PROD_W-1:0] dp_reg;
    logic [RED_W-1:0]       ds_reg;
    res_t                   det;
    res_t [8:0]             c5_reg, c6_reg, c7_reg, c8_reg, c9_reg;
    res_t                   dinv_reg;
    logic                   ok_reg;

    always_ff @(posedge aclk) begin
        if (ce[0]) begin
            for (int i = 0; i < 3; i++) begin
                dp_reg[i] <= PROD_W'(cin.row0[i]) * PROD_W'(cin.cof[i*3]);
            end
            c5_reg <= cin.cof;
        end
        if (ce[1]) begin
            ds_reg <= RED_W'(dp_reg[0]) + RED_W'(dp_reg[1]) + RED_W'(dp_reg[2]);
            c6_reg <= c5_reg;
        end
        if (ce[2]) c7_reg <= c6_reg;
        if (ce[3]) c8_reg <= c7_reg;
        // a zero table entry marks a determinant sharing a factor with 95
        if (ce[4]) begin
            dinv_reg <= INV_TBL[det];
            ok_reg   <= (INV_TBL[det] != '0);
            c9_reg   <= c8_reg;
        end
    end

    m3i_red95 u_red (
        .aclk (aclk),
        .ce   (ce[3:2]),
        .x    (ds_reg),
        .r    (det)
    );

    assign sout.cof  = c9_reg;
    assign sout.dinv = dinv_reg;
    assign sout.ok   = ok_reg;

endmodule

`default_nettype wire

// ===== rtl/m3i_scale.sv =====
// Scales each cofactor by the determinant inverse and reduces mod 95
// (3 stages, the last one is the result register). Depends on m3i_pkg, m3i_red95.
`default_nettype none

module m3i_scale (
    input  wire logic              aclk,
    input  wire logic [2:0]        ce,
    input  wire m3i_pkg::scl_bus_t sin,
    output      m3i_pkg::res_t [8:0] inv,
    output      logic              ok
);
    import m3i_pkg::*;

    logic [8:0][PROD_W-1:0] e_reg;
    logic                   ok0_reg, ok1_reg, ok2_reg;

    // a singular matrix has dinv zero, so every entry comes out zero
    always_ff @(posedge aclk) begin
        if (ce[0]) begin
            for (int k = 0; k < 9; k++) begin
                e_reg[k] <= PROD_W'(sin.cof[k]) * PROD_W'(sin.dinv);
            end
            ok0_reg <= sin.ok;
        end
        if (ce[1]) ok1_reg <= ok0_reg;
        if (ce[2]) ok2_reg <= ok1_reg;
    end

    for (genvar gk = 0; gk < 9; gk++) begin : g_red
        m3i_red95 u_red (
            .aclk (aclk),
            .ce   (ce[2:1]),
            .x    (RED_W'(e_reg[gk])),
            .r    (inv[gk])
        );
    end

    assign ok = ok2_reg;

endmodule

`default_nettype wire

// ===== rtl/matrix3_inverse_mod95.sv =====
// Inverse of a 3x3 matrix modulo 95 with an invertible flag.
//
// Input stream: s_axis_tdata carries nine 7-bit entries, row-major, entry_r0c0
// in the lowest bits; values 95..127 act as their residue. One item is taken
// whenever s_axis_tvalid and s_axis_tready are both high.
// Result stream: m_axis_tdata carries the nine 7-bit inverse entries in the
// same order, m_axis_tuser the invertible flag. A singular matrix (determinant
// sharing a factor with 95) gives invertible low and all entries zero.
//
// One item enters per cycle while m_axis_tready stays high, for a sustained
// rate of one result per cycle. The 13 stages are input reduction, cofactor
// products, cofactor difference, two reduction stages, determinant products,
// determinant sum, two reduction stages, inverse lookup, scaling products and
// two reduction stages ending in the result register.
// Each stage holds its own valid bit: a stalled receiver stops only the stages
// behind a full one, so empty slots fill up before s_axis_tready drops.
// Reset empties the pipeline; no item is in flight afterwards.
// Depends on m3i_pkg, m3i_cofactor, m3i_det, m3i_scale.
`default_nettype none

module matrix3_inverse_mod95 (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // entry_r0c0 .. entry_r2c2, 7 bits each; bit 63 zero
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [63:0] m_axis_tdata,   // inv_r0c0 .. inv_r2c2, 7 bits each; bit 63 zero
    output      logic        m_axis_tuser    // invertible
);
    import m3i_pkg::*;

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;
    logic [NSTG-1:0] ce;
    res_t [8:0]      raw;
    res_t [8:0]      inv;
    cof_bus_t        cob;
    scl_bus_t        scb;
    logic            ok;

    // a stage may load when it is empty or the stage after it moves on
    always_comb begin
        ce[NSTG-1] = !v_reg[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            ce[k] = !v_reg[k] || ce[k+1];
        end
    end

    assign v_next = (ce & {v_reg[NSTG-2:0], s_axis_tvalid}) | (~ce & v_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign raw = s_axis_tdata[9*RES_W-1:0];

    m3i_cofactor u_cof (
        .aclk (aclk),
        .ce   (ce[4:0]),
        .raw  (raw),
        .cob  (cob)
    );

    m3i_det u_det (
        .aclk (aclk),
        .ce   (ce[9:5]),
        .cin  (cob),
        .sout (scb)
    );

    m3i_scale u_scl (
        .aclk (aclk),
        .ce   (ce[12:10]),
        .sin  (scb),
        .inv  (inv),
        .ok   (ok)
    );

    assign s_axis_tready = ce[0];
    assign m_axis_tvalid = v_reg[NSTG-1];
    assign m_axis_tdata  = {1'b0, inv};
    assign m_axis_tuser  = ok;

endmodule

`default_nettype wire

// ===== rtl/m3i_chk.sv =====
// Port-level checks for matrix3_inverse_mod95, attached by the bind below.
// Depends only on the top level's ports.
`default_nettype none

module m3i_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    // a singular matrix yields an all-zero result
    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 64'd0))
        else $error("singular result carries nonzero entries");

    // every entry is a canonical residue and the pad bit is clear
    a_canonical: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[6:0] < 7'd95 && m_axis_tdata[13:7] < 7'd95 &&
            m_axis_tdata[20:14] < 7'd95 && m_axis_tdata[27:21] < 7'd95 &&
            m_axis_tdata[34:28] < 7'd95 && m_axis_tdata[41:35] < 7'd95 &&
            m_axis_tdata[48:42] < 7'd95 && m_axis_tdata[55:49] < 7'd95 &&
            m_axis_tdata[62:56] < 7'd95 && !m_axis_tdata[63]))
        else $error("result entry out of range");

    // the pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind matrix3_inverse_mod95 m3i_chk u_m3i_chk (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for matrix3_inverse_mod95: random and corner-case 3x3 matrices
// are checked against an internal modular-inverse predictor, with random stalls on both sides.
// Depends on m3i_pkg and the matrix3_inverse_mod95 RTL.
`timescale 1ns / 100ps

module testbench;

    import m3i_pkg::*;

    localparam int N_RANDOM       = 1800;
    localparam int IDLE_PCT       = 7;
    localparam int HOLD_CYCLES    = 80;
    localparam int HOLD_AT_ITEM   = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef logic [8:0][RES_W-1:0] matrix_t;

    typedef struct packed {
        matrix_t entry;        // inverse, row-major, r0c0 at index 0
        logic    invertible;
    } matrix_inv_t;

    logic          aclk;
    logic          aresetn       = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [63:0]   s_axis_tdata  = '0;    // entry_r0c0 .. entry_r2c2, 7 bits each; bit 63 zero
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [63:0]   m_axis_tdata;          // inv_r0c0 .. inv_r2c2, 7 bits each; bit 63 zero
    logic          m_axis_tuser;          // invertible

    matrix_t       matrix_q[$];
    matrix_inv_t   inverse_q[$];

    int            n_in        = 0;
    int            n_out       = 0;
    int            n_invertible = 0;
    int            n_err       = 0;
    int            hold_left   = 0;
    logic          hold_done   = 1'b0;
    int            quiet       = 0;

    // no random idling on either side while this window of items passes
    wire calm = (n_in >= 900) && (n_in < 1300);

    matrix3_inverse_mod95 DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int wrap95(input int v);
        int r;
        r = v % MODULUS;
        return (r < 0) ? r + MODULUS : r;
    endfunction

    function automatic matrix_t mat(input int e0, e1, e2, e3, e4, e5, e6, e7, e8);
        matrix_t m;
        m[0] = RES_W'(e0); m[1] = RES_W'(e1); m[2] = RES_W'(e2);
        m[3] = RES_W'(e3); m[4] = RES_W'(e4); m[5] = RES_W'(e5);
        m[6] = RES_W'(e6); m[7] = RES_W'(e7); m[8] = RES_W'(e8);
        return m;
    endfunction

    // Adjugate times determinant inverse, all mod 95; zeros when det shares 5 or 19.
    function automatic matrix_inv_t predict_inverse(input matrix_t m);
        matrix_inv_t r;
        int a [3][3];
        int det, det_inv, cof, ra, rb, ca, cb;
        r = '0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                a[i][j] = int'(m[i*3 + j]);
        det = a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
            - a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
            + a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
        det = wrap95(det);
        if (det % 5 == 0 || det % 19 == 0)
            return r;
        det_inv = 0;
        for (int k = 1; k < MODULUS; k++)
            if ((det * k) % MODULUS == 1)
                det_inv = k;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                // entry (i,j) takes the cofactor of source entry (j,i)
                ra = (j + 1) % 3; rb = (j + 2) % 3;
                ca = (i + 1) % 3; cb = (i + 2) % 3;
                cof = wrap95(a[ra][ca] * a[rb][cb] - a[ra][cb] * a[rb][ca]);
                r.entry[i*3 + j] = RES_W'(wrap95(cof * det_inv));
            end
        end
        r.invertible = 1'b1;
        return r;
    endfunction

    // Driver: offer the next matrix once the current one is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                inverse_q.push_back(predict_inverse(s_axis_tdata[62:0]));
                n_in <= n_in + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (matrix_q.size() != 0 &&
                    (calm || hold_left != 0 || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    s_axis_tdata  <= {1'b0, matrix_q.pop_front()};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result against the oldest prediction, drive tready.
    always @(posedge aclk) begin
        matrix_inv_t want;
        logic        bad;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_out++;
                if (inverse_q.size() == 0) begin
                    n_err++;
                    if (n_err <= MAX_REPORTS)
                        $display("unexpected result: tdata=%h tuser=%b",
                                 m_axis_tdata, m_axis_tuser);
                end else begin
                    want = inverse_q.pop_front();
                    bad  = (m_axis_tuser !== want.invertible) || (m_axis_tdata[63] !== 1'b0);
                    for (int k = 0; k < 9; k++)
                        if (m_axis_tdata[k*RES_W +: RES_W] !== want.entry[k])
                            bad = 1'b1;
                    n_invertible += want.invertible;
                    if (bad) begin
                        n_err++;
                        if (n_err <= MAX_REPORTS)
                            $display("result %0d mismatch: expected tdata=%h tuser=%b, got tdata=%h tuser=%b",
                                     n_out, {1'b0, want.entry}, want.invertible,
                                     m_axis_tdata, m_axis_tuser);
                    end
                end
            end
            // one long hold-off so the pipeline fills and backs up into the input
            if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && n_in >= HOLD_AT_ITEM) begin
                hold_left     <= HOLD_CYCLES;
                hold_done     <= 1'b1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: end the run if neither side moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        matrix_t m;
        int      kind, mul;
        int      picks [7];

        picks = '{0, 1, 93, 94, 95, 126, 127};

        // corner cases
        matrix_q.push_back(mat(0, 0, 0, 0, 0, 0, 0, 0, 0));             // all zero, det 0
        matrix_q.push_back(mat(94, 94, 94, 94, 94, 94, 94, 94, 94));    // rank one
        matrix_q.push_back(mat(127, 127, 127, 127, 127, 127, 127, 127, 127));
        matrix_q.push_back(mat(1, 0, 0, 0, 1, 0, 0, 0, 1));             // identity, det one
        matrix_q.push_back(mat(0, 1, 0, 0, 0, 1, 1, 0, 0));             // permutation, det one
        matrix_q.push_back(mat(0, 1, 0, 1, 0, 0, 0, 0, 1));             // det -1
        matrix_q.push_back(mat(94, 0, 0, 0, 94, 0, 0, 0, 94));          // det 94
        matrix_q.push_back(mat(5, 0, 0, 0, 1, 0, 0, 0, 1));             // det 5
        matrix_q.push_back(mat(19, 0, 0, 0, 1, 0, 0, 0, 1));            // det 19
        matrix_q.push_back(mat(5, 0, 0, 0, 19, 0, 0, 0, 1));            // det 95
        matrix_q.push_back(mat(3, 0, 0, 0, 5, 0, 0, 0, 7));             // det 105, factor 5
        matrix_q.push_back(mat(96, 0, 0, 0, 1, 0, 0, 0, 1));            // raw 96 acts as 1
        matrix_q.push_back(mat(127, 0, 0, 0, 1, 0, 0, 0, 1));           // raw 127 acts as 32
        matrix_q.push_back(mat(95, 1, 0, 0, 95, 1, 1, 0, 95));          // raw 95 acts as 0
        matrix_q.push_back(mat(6, 24, 1, 13, 16, 10, 20, 17, 15));
        matrix_q.push_back(mat(2, 3, 5, 7, 11, 13, 17, 23, 29));
        matrix_q.push_back(mat(1, 2, 3, 4, 5, 6, 7, 8, 10));
        matrix_q.push_back(mat(94, 1, 94, 1, 94, 1, 94, 1, 93));
        matrix_q.push_back(mat(1, 2, 3, 2, 4, 6, 9, 8, 7));             // dependent rows
        matrix_q.push_back(mat(127, 0, 127, 0, 127, 0, 127, 0, 0));
        matrix_q.push_back(mat(93, 94, 0, 1, 93, 94, 94, 0, 1));

        for (int n = 0; n < N_RANDOM; n++) begin
            kind = $urandom_range(0, 99);
            for (int k = 0; k < 9; k++)
                m[k] = RES_W'($urandom_range(0, MODULUS - 1));
            if (kind >= 70 && kind < 80) begin
                // raw values over the full field range
                for (int k = 0; k < 9; k++)
                    m[k] = RES_W'($urandom_range(0, 127));
            end else if (kind >= 80 && kind < 90) begin
                // bottom row a multiple of the top row: determinant zero
                mul = $urandom_range(0, MODULUS - 1);
                for (int k = 0; k < 3; k++)
                    m[6 + k] = RES_W'(wrap95(int'(m[k]) * mul));
            end else if (kind >= 90) begin
                for (int k = 0; k < 9; k++)
                    if ($urandom_range(0, 1) == 1)
                        m[k] = RES_W'(picks[$urandom_range(0, 6)]);
            end
            matrix_q.push_back(m);
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (matrix_q.size() != 0 || s_axis_tvalid || inverse_q.size() != 0)
            @(posedge aclk);
        // catch any stray result after the last expected one
        repeat (2 * NSTG + 10) @(posedge aclk);

        $display("covered %0d matrices (%0d invertible, %0d singular), with one long output stall",
                 n_in, n_invertible, n_out - n_invertible);
        $display("and %0d mismatching or unexpected results", n_err);
        if (n_err == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
